/* design/abrba_pkg.sv */
// shared constants, types and arithmetic helpers for the beam angle pipeline
// no dependencies; used by abrba_sincos, abrba_atan2 and the top level
package abrba_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 18;
  localparam int TURN_BITS      = 32;
  localparam int TURN_SHIFT     = TURN_BITS - ANGLE_BITS;

  localparam int TW  = TRIG_FRAC_BITS + 4;
  localparam int VW  = TRIG_FRAC_BITS + 6;
  localparam int ZW  = TURN_BITS + 2;
  localparam int RW  = ANGLE_BITS + 1;
  localparam int HSW = ANGLE_BITS + 2;
  localparam int SQW = 2 * TRIG_FRAC_BITS + 1;

  localparam int SC_LAT   = TRIG_FRAC_BITS + 2;
  localparam int MUL_LAT  = 4;
  localparam int PREP_LAT = 2;
  localparam int SQ_STEPS = TRIG_FRAC_BITS + 1;
  localparam int AT_LAT   = TRIG_FRAC_BITS + 3;
  localparam int LAM_DLY  = PREP_LAT + SQ_STEPS;
  localparam int HD_DLY   = SC_LAT + MUL_LAT + PREP_LAT + SQ_STEPS + AT_LAT;

  localparam int     GAIN_SHIFT = 30 - TRIG_FRAC_BITS;
  localparam longint GAIN_Q30   = 652032874;
  localparam longint X_INIT     = (GAIN_SHIFT == 0) ? GAIN_Q30 :
    ((GAIN_Q30 + (64'sd1 <<< ((GAIN_SHIFT > 0) ? GAIN_SHIFT - 1 : 0))) >>> GAIN_SHIFT);

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(1) << (TURN_BITS - 1);
  localparam logic signed [ZW-1:0] FULL_TURN = ZW'(1) << TURN_BITS;
  localparam logic signed [TW-1:0] ONE_Q     = TW'(1) << TRIG_FRAC_BITS;

  // atan(2^-i) in 32-bit turns
  localparam logic [31:0] ATAN_TURNS [0:30] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
  };

  typedef logic signed [TW-1:0] trig_t;

  // product rounded half away from zero back to the trig fraction
  function automatic trig_t qmul(input trig_t a, input trig_t b);
    logic signed [2*TW-1:0] p;
    logic signed [2*TW-1:0] q;
    p = (2*TW)'(a) * (2*TW)'(b);
    q = p + ((2*TW)'(1) << (TRIG_FRAC_BITS - 1)) - (2*TW)'(p[2*TW-1]);
    qmul = TW'(q >>> TRIG_FRAC_BITS);
  endfunction

  // turn to output units, rounded half away from zero
  function automatic logic signed [RW-1:0] round_turn(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] q;
    q = z + (ZW'(1) << (TURN_SHIFT - 1)) - ZW'(z[ZW-1]);
    round_turn = RW'(q >>> TURN_SHIFT);
  endfunction

endpackage

/* design/airborne_radar_beam_angles.sv */
// throughput: one beam per cycle; busy stays low, results cannot be held off
// reset (synchronous, active low) clears the valid bits of every stage only
// depends on abrba_pkg, abrba_sincos and abrba_atan2
module airborne_radar_beam_angles (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [abrba_pkg::ANGLE_BITS-1:0] in_roll_in,
  input  logic signed [abrba_pkg::ANGLE_BITS-1:0] in_pitch_in,
  input  logic [abrba_pkg::ANGLE_BITS-1:0]        in_heading_in,
  input  logic signed [abrba_pkg::ANGLE_BITS-1:0] in_drift_in,
  input  logic [abrba_pkg::ANGLE_BITS-1:0]        in_antenna_rotation_in,
  input  logic signed [abrba_pkg::ANGLE_BITS-1:0] in_antenna_tilt_in,
  input  logic [5:0]                              in_missing_mask,
  output logic                                    out_valid,
  output logic [abrba_pkg::ANGLE_BITS-1:0]        out_track_rotation,
  output logic signed [abrba_pkg::ANGLE_BITS-1:0] out_track_tilt,
  output logic signed [abrba_pkg::ANGLE_BITS:0]   out_track_azimuth,
  output logic signed [abrba_pkg::ANGLE_BITS-1:0] out_track_elevation
);
  localparam int AB  = abrba_pkg::ANGLE_BITS;
  localparam int TF  = abrba_pkg::TRIG_FRAC_BITS;
  localparam int TB  = abrba_pkg::TURN_BITS;
  localparam int TS  = abrba_pkg::TURN_SHIFT;
  localparam int TW  = abrba_pkg::TW;
  localparam int RW  = abrba_pkg::RW;
  localparam int HSW = abrba_pkg::HSW;
  localparam int SQW = abrba_pkg::SQW;
  localparam int SQN = abrba_pkg::SQ_STEPS;
  localparam int LD  = abrba_pkg::LAM_DLY;
  localparam int HD  = abrba_pkg::HD_DLY;
  localparam logic signed [RW:0]   QTR    = (RW+1)'(1) << (AB - 2);
  localparam logic signed [RW+1:0] TURN_U = (RW+2)'(1) << AB;

  logic                   accept_w;
  logic                   in_vld_r;
  logic [AB-1:0]          roll_r, pitch_r, head_r, drift_r, rot_r, tilt_r;
  logic [TB-1:0]          sc_ang_w [4];
  logic [3:0]             sc_vld;
  abrba_pkg::trig_t       sin_w [4];
  abrba_pkg::trig_t       cos_w [4];
  logic signed [HSW-1:0]  hs_w;

  // products of the beam vector, one multiply level per stage, then the sums of vx, vy and vz
  logic [3:0]             mv_r;
  abrba_pkg::trig_t       a1_r, b1_r, c1_r, d1_r, e1_r, f1_r, g1_r, h1_r;
  abrba_pkg::trig_t       cta1_r, sta1_r, sp1_r, crc1_r;
  abrba_pkg::trig_t       a2_r, b2_r, c2_r, d2_r, e2_r, f2_r, g2_r, h2_r, sp2_r;
  abrba_pkg::trig_t       a3_r, b3_r, c3_r, d3_r, e3_r, f3_r, g3_r, h3_r;
  abrba_pkg::trig_t       vx_r, vy_r, vz_r;

  logic [1:0]             at_vld;
  logic signed [RW-1:0]   at_ang [2];
  logic signed [RW-1:0]   rot_d_r [LD];
  logic signed [RW-1:0]   lam_d_r [LD];
  logic signed [HSW-1:0]  hs_d_r [HD];

  abrba_pkg::trig_t       vin_w [2];
  abrba_pkg::trig_t       vs_w [2];
  logic signed [2*TW-1:0] sqp_w [2];
  logic                   pv_vld_r;
  abrba_pkg::trig_t       pv_r [2];
  logic [SQW-1:0]         psq_r [2];
  logic [SQN:0]           sq_vld_r;
  logic [SQW-1:0]         sqn_r [2][SQN+1];
  logic [SQW-1:0]         sqr_r [2][SQN+1];
  abrba_pkg::trig_t       sqv_r [2][SQN+1];
  logic [1:0]             as_vld;
  logic signed [RW-1:0]   as_ang [2];

  logic signed [RW+1:0]   az_sum_w;
  logic                   out_valid_r;
  logic [AB-1:0]          rot_out_r;
  logic signed [AB-1:0]   tilt_out_r;
  logic signed [AB:0]     az_out_r;
  logic signed [AB-1:0]   elev_out_r;

  assign busy     = 1'b0;
  assign accept_w = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept_w;
    end
  end

  // missing angles count as zero
  always_ff @(posedge clk) begin
    roll_r  <= in_missing_mask[0] ? '0 : in_roll_in;
    pitch_r <= in_missing_mask[1] ? '0 : in_pitch_in;
    head_r  <= in_missing_mask[2] ? '0 : in_heading_in;
    drift_r <= in_missing_mask[3] ? '0 : in_drift_in;
    rot_r   <= in_missing_mask[4] ? '0 : in_antenna_rotation_in;
    tilt_r  <= in_missing_mask[5] ? '0 : in_antenna_tilt_in;
  end

  assign sc_ang_w[0] = TB'(pitch_r) << TS;
  assign sc_ang_w[1] = TB'(drift_r) << TS;
  assign sc_ang_w[2] = TB'(tilt_r) << TS;
  assign sc_ang_w[3] = (TB'(rot_r) << TS) + (TB'(roll_r) << TS);
  assign hs_w = HSW'(signed'({1'b0, head_r})) + HSW'(signed'(drift_r));

  for (genvar u = 0; u < 4; u++) begin : g_sc
    abrba_sincos u_sc (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (in_vld_r),
      .ang     (sc_ang_w[u]),
      .out_vld (sc_vld[u]),
      .sin_o   (sin_w[u]),
      .cos_o   (cos_w[u])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= '0;
    end else begin
      mv_r <= {mv_r[2:0], sc_vld[0]};
    end
  end

  // lanes: 0 pitch, 1 drift, 2 antenna tilt, 3 roll-corrected rotation
  always_ff @(posedge clk) begin
    a1_r   <= abrba_pkg::qmul(cos_w[3], sin_w[1]);
    b1_r   <= abrba_pkg::qmul(cos_w[1], sin_w[3]);
    c1_r   <= abrba_pkg::qmul(sin_w[1], cos_w[0]);
    d1_r   <= abrba_pkg::qmul(cos_w[3], cos_w[1]);
    e1_r   <= abrba_pkg::qmul(sin_w[1], sin_w[3]);
    f1_r   <= abrba_pkg::qmul(cos_w[0], cos_w[1]);
    g1_r   <= abrba_pkg::qmul(cos_w[0], cos_w[2]);
    h1_r   <= abrba_pkg::qmul(sin_w[0], sin_w[2]);
    cta1_r <= cos_w[2];
    sta1_r <= sin_w[2];
    sp1_r  <= sin_w[0];
    crc1_r <= cos_w[3];

    a2_r  <= abrba_pkg::qmul(a1_r, cta1_r);
    b2_r  <= abrba_pkg::qmul(b1_r, cta1_r);
    c2_r  <= abrba_pkg::qmul(c1_r, sta1_r);
    d2_r  <= abrba_pkg::qmul(d1_r, cta1_r);
    e2_r  <= abrba_pkg::qmul(e1_r, cta1_r);
    f2_r  <= abrba_pkg::qmul(f1_r, sta1_r);
    g2_r  <= abrba_pkg::qmul(g1_r, crc1_r);
    h2_r  <= h1_r;
    sp2_r <= sp1_r;

    a3_r <= abrba_pkg::qmul(a2_r, sp2_r);
    d3_r <= abrba_pkg::qmul(d2_r, sp2_r);
    b3_r <= b2_r;
    c3_r <= c2_r;
    e3_r <= e2_r;
    f3_r <= f2_r;
    g3_r <= g2_r;
    h3_r <= h2_r;

    vx_r <= a3_r + b3_r - c3_r;
    vy_r <= e3_r + f3_r - d3_r;
    vz_r <= g3_r + h3_r;
  end

  abrba_atan2 u_at_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (mv_r[3]),
    .y_i     (vx_r),
    .x_i     (vz_r),
    .out_vld (at_vld[0]),
    .ang_o   (at_ang[0])
  );

  abrba_atan2 u_at_lam (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (mv_r[3]),
    .y_i     (vx_r),
    .x_i     (vy_r),
    .out_vld (at_vld[1]),
    .ang_o   (at_ang[1])
  );

  always_ff @(posedge clk) begin
    rot_d_r[0] <= at_ang[0];
    lam_d_r[0] <= at_ang[1];
    for (int k = 1; k < LD; k++) begin
      rot_d_r[k] <= rot_d_r[k-1];
      lam_d_r[k] <= lam_d_r[k-1];
    end
    hs_d_r[0] <= hs_w;
    for (int k = 1; k < HD; k++) begin
      hs_d_r[k] <= hs_d_r[k-1];
    end
  end

  // asin(v) = atan2(v, isqrt(1 - v^2)), lane 0 tilt from y, lane 1 elevation from z
  assign vin_w[0] = vy_r;
  assign vin_w[1] = vz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_vld_r <= 1'b0;
      sq_vld_r <= '0;
    end else begin
      pv_vld_r <= mv_r[3];
      sq_vld_r <= {sq_vld_r[SQN-1:0], pv_vld_r};
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_asin
    assign vs_w[l] = (vin_w[l] > abrba_pkg::ONE_Q) ? abrba_pkg::ONE_Q :
                     (vin_w[l] < -abrba_pkg::ONE_Q) ? -abrba_pkg::ONE_Q : vin_w[l];
    assign sqp_w[l] = (2*TW)'(vs_w[l]) * (2*TW)'(vs_w[l]);

    always_ff @(posedge clk) begin
      pv_r[l]     <= vs_w[l];
      psq_r[l]    <= SQW'(sqp_w[l]);
      sqn_r[l][0] <= (SQW'(1) << (2 * TF)) - psq_r[l];
      sqr_r[l][0] <= '0;
      sqv_r[l][0] <= pv_r[l];
    end

    for (genvar k = 0; k < SQN; k++) begin : g_sq
      localparam logic [SQW-1:0] SQ_BIT = SQW'(1) << (2 * (SQN - 1 - k));
      logic [SQW:0] tst_w;
      logic         ge_w;
      assign tst_w = {1'b0, sqr_r[l][k]} + {1'b0, SQ_BIT};
      assign ge_w  = {1'b0, sqn_r[l][k]} >= tst_w;
      always_ff @(posedge clk) begin
        if (ge_w) begin
          sqn_r[l][k+1] <= sqn_r[l][k] - tst_w[SQW-1:0];
          sqr_r[l][k+1] <= (sqr_r[l][k] >> 1) + SQ_BIT;
        end else begin
          sqn_r[l][k+1] <= sqn_r[l][k];
          sqr_r[l][k+1] <= sqr_r[l][k] >> 1;
        end
        sqv_r[l][k+1] <= sqv_r[l][k];
      end
    end

    abrba_atan2 u_at_asin (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (sq_vld_r[SQN]),
      .y_i     (sqv_r[l][SQN]),
      .x_i     (signed'(TW'(sqr_r[l][SQN]))),
      .out_vld (as_vld[l]),
      .ang_o   (as_ang[l])
    );
  end

  assign az_sum_w = (RW+2)'(lam_d_r[LD-1]) + (RW+2)'(hs_d_r[HD-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= as_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    rot_out_r <= rot_d_r[LD-1][AB-1:0];
    if ((RW+1)'(as_ang[0]) > QTR) begin
      tilt_out_r <= AB'(QTR);
    end else if ((RW+1)'(as_ang[0]) < -QTR) begin
      tilt_out_r <= AB'(-QTR);
    end else begin
      tilt_out_r <= as_ang[0][AB-1:0];
    end
    if ((RW+1)'(as_ang[1]) > QTR) begin
      elev_out_r <= AB'(QTR);
    end else if ((RW+1)'(as_ang[1]) < -QTR) begin
      elev_out_r <= AB'(-QTR);
    end else begin
      elev_out_r <= as_ang[1][AB-1:0];
    end
    // remainder toward zero by one turn
    if (az_sum_w >= TURN_U) begin
      az_out_r <= (AB+1)'(az_sum_w - TURN_U);
    end else if (az_sum_w <= -TURN_U) begin
      az_out_r <= (AB+1)'(az_sum_w + TURN_U);
    end else begin
      az_out_r <= (AB+1)'(az_sum_w);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_track_rotation  = rot_out_r;
  assign out_track_tilt      = tilt_out_r;
  assign out_track_azimuth   = az_out_r;
  assign out_track_elevation = elev_out_r;

`ifndef SYNTHESIS
  a_sc_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (&sc_vld) || !(|sc_vld))
    else $error("sine/cosine lanes out of step");
  a_at_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    at_vld[0] == at_vld[1])
    else $error("rotation and azimuth lanes out of step");
  a_as_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    as_vld[0] == as_vld[1])
    else $error("tilt and elevation lanes out of step");
  a_tilt_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_track_tilt <= AB'(QTR)) && (out_track_tilt >= AB'(-QTR))))
    else $error("tilt beyond a quarter turn");
  a_az_lag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(as_vld[0]))
    else $error("result beat without a finished beam");
`endif

endmodule

/* design/abrba_sincos.sv */
// pipelined rotation-mode cordic: sine and cosine of a 32-bit turn
// depends on abrba_pkg
module abrba_sincos (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic [abrba_pkg::TURN_BITS-1:0]     ang,
  output logic                                out_vld,
  output logic signed [abrba_pkg::TW-1:0]     sin_o,
  output logic signed [abrba_pkg::TW-1:0]     cos_o
);
  localparam int N  = abrba_pkg::TRIG_FRAC_BITS;
  localparam int TB = abrba_pkg::TURN_BITS;
  localparam int TW = abrba_pkg::TW;
  localparam int ZW = abrba_pkg::ZW;

  logic [TB-1:0]        qtr_w;
  logic [TB-1:0]        af_w;
  logic                 flip_w;
  logic [N+1:0]         vld_r;
  logic signed [TW-1:0] x_r [N+1];
  logic signed [TW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  logic [N:0]           flip_r;
  logic signed [TW-1:0] sin_r;
  logic signed [TW-1:0] cos_r;

  assign qtr_w  = ang + (TB'(1) << (TB - 2));
  assign flip_w = qtr_w[TB-1];
  assign af_w   = flip_w ? (ang ^ (TB'(1) << (TB - 1))) : ang;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= TW'(abrba_pkg::X_INIT);
    y_r[0]    <= '0;
    z_r[0]    <= ZW'(signed'(af_w));
    flip_r[0] <= flip_w;
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (z_r[i][ZW-1]) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ZW'(abrba_pkg::ATAN_TURNS[i]);
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ZW'(abrba_pkg::ATAN_TURNS[i]);
      end
      flip_r[i+1] <= flip_r[i];
    end
  end

  always_ff @(posedge clk) begin
    sin_r <= flip_r[N] ? -y_r[N] : y_r[N];
    cos_r <= flip_r[N] ? -x_r[N] : x_r[N];
  end

  assign out_vld = vld_r[N+1];
  assign sin_o   = sin_r;
  assign cos_o   = cos_r;

endmodule

/* design/abrba_atan2.sv */
// pipelined vectoring-mode cordic: atan2(y, x) rounded to output angle units
// depends on abrba_pkg
module abrba_atan2 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  logic signed [abrba_pkg::TW-1:0]     y_i,
  input  logic signed [abrba_pkg::TW-1:0]     x_i,
  output logic                                out_vld,
  output logic signed [abrba_pkg::RW-1:0]     ang_o
);
  localparam int N  = abrba_pkg::TRIG_FRAC_BITS;
  localparam int VW = abrba_pkg::VW;
  localparam int ZW = abrba_pkg::ZW;
  localparam int RW = abrba_pkg::RW;

  logic signed [VW-1:0] xe_w;
  logic signed [VW-1:0] ye_w;
  logic                 neg_w;
  logic [N+2:0]         vld_r;
  logic signed [VW-1:0] x_r [N+1];
  logic signed [VW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  logic [N:0]           zero_r;
  logic signed [ZW-1:0] zw_r;
  logic signed [RW-1:0] ang_r;

  assign xe_w  = VW'(x_i);
  assign ye_w  = VW'(y_i);
  assign neg_w = x_i[abrba_pkg::TW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N+1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= neg_w ? -xe_w : xe_w;
    y_r[0]    <= neg_w ? -ye_w : ye_w;
    z_r[0]    <= neg_w ? abrba_pkg::HALF_TURN : '0;
    zero_r[0] <= (x_i == '0) && (y_i == '0);
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (!y_r[i][VW-1] && (y_r[i] != '0)) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ZW'(abrba_pkg::ATAN_TURNS[i]);
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ZW'(abrba_pkg::ATAN_TURNS[i]);
      end
      zero_r[i+1] <= zero_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (zero_r[N]) begin
      zw_r <= '0;
    end else if (z_r[N] > abrba_pkg::HALF_TURN) begin
      zw_r <= z_r[N] - abrba_pkg::FULL_TURN;
    end else begin
      zw_r <= z_r[N];
    end
    ang_r <= abrba_pkg::round_turn(zw_r);
  end

  assign out_vld = vld_r[N+2];
  assign ang_o   = ang_r;

endmodule
